### rtl/kdp_pkg.sv
package kdp_pkg;

  localparam int MAX_ITEMS_DEF    = 32;
  localparam int MAX_CAPACITY_DEF = 255;
  localparam int VAL_W            = 21;
  localparam int WGT_W            = 8;
  localparam int ITV_W            = 16;
  localparam int CFG_W            = 8;

  localparam logic RK_VALUE  = 1'b0;
  localparam logic RK_WEIGHT = 1'b1;

  typedef struct packed {
    logic [WGT_W-1:0] weight;
    logic [ITV_W-1:0] value;
    logic             last;
  } kdp_item_t;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
    logic             dropped;
    logic             last;
  } kdp_result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_TR_INIT,
    ST_TR_BEST,
    ST_TR_RD,
    ST_TR_CHK,
    ST_EMIT
  } kdp_state_t;

endpackage

### rtl/kdp_front.sv
module kdp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kdp_pkg::kdp_item_t in_item,
  output logic              q_valid,
  output kdp_pkg::kdp_item_t q_item,
  input  logic              q_pop
);
  import kdp_pkg::*;

  kdp_item_t  buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### rtl/kdp_back.sv
module kdp_back #(
  parameter int MAX_ITEMS    = kdp_pkg::MAX_ITEMS_DEF,
  parameter int MAX_CAPACITY = kdp_pkg::MAX_CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [kdp_pkg::CFG_W-1:0]  capacity,
  input  logic                       q_valid,
  input  kdp_pkg::kdp_item_t         q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output kdp_pkg::kdp_result_t       out_res
);
  import kdp_pkg::*;

  localparam int ROW_LEN = MAX_CAPACITY + 1;
  localparam int CAP_W   = $clog2(MAX_CAPACITY + 1);
  localparam int IX_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int EW      = ((CAP_W > WGT_W) ? CAP_W : WGT_W) + 1;
  localparam int KEEP_D  = 2 ** (IX_W + CAP_W);
  localparam logic [CAP_W-1:0] CAP_MAX  = CAP_W'(MAX_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);
  localparam logic [VAL_W:0]   VAL_SAT  = {1'b0, {VAL_W{1'b1}}};

  kdp_state_t state_r, state_nxt;

  logic [VAL_W-1:0] best_mem [ROW_LEN];
  logic             keep_mem [KEEP_D];
  logic [WGT_W-1:0] wt_mem   [MAX_ITEMS];
  logic [WGT_W-1:0] ch_mem   [MAX_ITEMS];

  logic [CAP_W-1:0] j_r;
  logic [WGT_W-1:0] w_r;
  logic [ITV_W-1:0] v_r;
  logic             last_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             s1_v_r;
  logic             s1_fit_r;
  logic [CAP_W-1:0] s1_j_r;
  logic [VAL_W-1:0] rd_a_r;
  logic [VAL_W-1:0] rd_b_r;
  logic [VAL_W-1:0] best_r;
  logic [IX_W-1:0]  ti_r;
  logic [CAP_W-1:0] tj_r;
  logic             keep_rd_r;
  logic [WGT_W-1:0] wt_rd_r;
  logic [CNT_W-1:0] nch_r;
  logic [CNT_W-1:0] emit_idx_r;
  logic             val_done_r;
  logic [WGT_W-1:0] ch_rd_r;
  logic             out_valid_r;
  kdp_result_t      out_res_r;

  logic [CAP_W-1:0] cap_use;
  logic [EW-1:0]    j_ext, w_ext, tj_ext, twt_ext;
  logic             fit;
  logic [CAP_W-1:0] addr_a, addr_b;
  logic             best_we;
  logic [CAP_W-1:0] best_waddr;
  logic [VAL_W-1:0] best_wdata;
  logic             keep_we;
  logic             take;
  logic [VAL_W:0]   cand;
  logic [VAL_W-1:0] cand_sat;
  logic             load;
  logic             emit_done;
  logic             accept_item;
  logic [IX_W-1:0]  ch_raddr;
  kdp_result_t      res_nxt;

  assign cap_use = (32'(capacity) > MAX_CAPACITY) ? CAP_MAX : CAP_W'(capacity);
  assign j_ext   = EW'(j_r);
  assign w_ext   = EW'(w_r);
  assign fit     = (w_ext <= j_ext);
  assign tj_ext  = EW'(tj_r);
  assign twt_ext = EW'(wt_rd_r);

  assign cand     = {1'b0, rd_b_r} + (VAL_W + 1)'(v_r);
  assign cand_sat = (cand > VAL_SAT) ? {VAL_W{1'b1}} : cand[VAL_W-1:0];
  assign take     = s1_fit_r && (cand_sat > rd_a_r);

  assign load        = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign accept_item = (cnt_r != CNT_FULL);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (j_r == '0) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          if (accept_item)       state_nxt = ST_SWEEP;
          else if (q_item.last)  state_nxt = ST_TR_INIT;
        end
      end
      ST_SWEEP: begin
        if (j_r == '0) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = last_r ? ST_TR_INIT : ST_IDLE;
      end
      ST_TR_INIT: state_nxt = ST_TR_BEST;
      ST_TR_BEST: begin
        state_nxt = (cnt_r == '0) ? ST_EMIT : ST_TR_RD;
      end
      ST_TR_RD:  state_nxt = ST_TR_CHK;
      ST_TR_CHK: begin
        state_nxt = (ti_r == '0) ? ST_EMIT : ST_TR_RD;
      end
      ST_EMIT: begin
        if (load && emit_done) state_nxt = ST_CLEAR;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath controls
  always_comb begin
    q_pop      = 1'b0;
    addr_a     = j_r;
    addr_b     = fit ? CAP_W'(j_ext - w_ext) : '0;
    best_we    = 1'b0;
    best_waddr = s1_j_r;
    best_wdata = cand_sat;
    keep_we    = 1'b0;
    emit_done  = 1'b0;
    res_nxt    = '0;
    unique case (state_r)
      ST_CLEAR: begin
        best_we    = 1'b1;
        best_waddr = j_r;
        best_wdata = '0;
      end
      ST_IDLE: q_pop = q_valid;
      ST_SWEEP, ST_DRAIN: begin
        best_we = s1_v_r && take;
        keep_we = s1_v_r;
      end
      ST_TR_INIT: addr_a = cap_use;
      ST_EMIT: begin
        if (!val_done_r) begin
          res_nxt.kind    = RK_VALUE;
          res_nxt.value   = best_r;
          res_nxt.dropped = ovf_r;
          res_nxt.last    = (nch_r == '0);
        end else begin
          res_nxt.kind    = RK_WEIGHT;
          res_nxt.value   = VAL_W'(ch_rd_r);
          res_nxt.dropped = 1'b0;
          res_nxt.last    = (emit_idx_r + 1'b1 == nch_r);
        end
        emit_done = res_nxt.last;
      end
      default: ;
    endcase
  end

  assign ch_raddr = (load && val_done_r) ? IX_W'(emit_idx_r + 1'b1) : IX_W'(emit_idx_r);

  // memories
  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_waddr] <= best_wdata;
    end
    rd_a_r <= best_mem[addr_a];
    rd_b_r <= best_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (keep_we) begin
      keep_mem[{cnt_r[IX_W-1:0], s1_j_r}] <= take;
    end
    keep_rd_r <= keep_mem[{ti_r, tj_r}];
  end

  always_ff @(posedge clk) begin
    if (q_pop && accept_item) begin
      wt_mem[cnt_r[IX_W-1:0]] <= q_item.weight;
    end
    wt_rd_r <= wt_mem[ti_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_TR_CHK && keep_rd_r) begin
      ch_mem[nch_r[IX_W-1:0]] <= wt_rd_r;
    end
    ch_rd_r <= ch_mem[ch_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_r    <= q_item.weight;
      v_r    <= q_item.value;
      last_r <= q_item.last;
    end
    s1_fit_r <= fit;
    s1_j_r   <= j_r;
    if (state_r == ST_TR_BEST) begin
      best_r <= rd_a_r;
    end
    if (load) begin
      out_res_r <= res_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      j_r         <= CAP_MAX;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      ti_r        <= '0;
      tj_r        <= '0;
      nch_r       <= '0;
      emit_idx_r  <= '0;
      val_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= (state_r == ST_SWEEP);
      unique case (state_r)
        ST_CLEAR: begin
          if (j_r != '0) j_r <= j_r - 1'b1;
        end
        ST_IDLE: begin
          j_r <= CAP_MAX;
          if (q_valid && !accept_item) ovf_r <= 1'b1;
        end
        ST_SWEEP: begin
          if (j_r != '0) j_r <= j_r - 1'b1;
        end
        ST_DRAIN: cnt_r <= cnt_r + 1'b1;
        ST_TR_INIT: tj_r <= cap_use;
        ST_TR_BEST: ti_r <= IX_W'(cnt_r - 1'b1);
        ST_TR_CHK: begin
          if (keep_rd_r) begin
            nch_r <= nch_r + 1'b1;
            tj_r  <= (twt_ext <= tj_ext) ? CAP_W'(tj_ext - twt_ext) : '0;
          end
          if (ti_r != '0) ti_r <= ti_r - 1'b1;
        end
        ST_EMIT: begin
          if (load) begin
            if (emit_done) begin
              // start the row clear and drop per-problem counters
              j_r        <= CAP_MAX;
              cnt_r      <= '0;
              ovf_r      <= 1'b0;
              nch_r      <= '0;
              emit_idx_r <= '0;
              val_done_r <= 1'b0;
            end else begin
              if (val_done_r) emit_idx_r <= emit_idx_r + 1'b1;
              val_done_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

### rtl/knapsack_01_dp_with_traceback_top.sv
// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  item_weight, item_value, last_item
// out_      output     out_valid/out_stall  result_kind, result_value, items_dropped,
//                                           last_result
// cfg_      input      cfg_valid/cfg_ready  capacity (8 bits)
//
// Each held item makes one best-row read-modify-write per capacity through the
// two-read, one-write row memory. An ignored item only sets the drop flag.
// Traceback visits each held item, the last one first. After reset and after
// each problem the row is cleared while items wait in the two-word queue.
// Reset is synchronous, active low. out_stall holds the result register; the queue
// fills and raises in_stall.
module knapsack_01_dp_with_traceback_top #(
  parameter int MAX_ITEMS    = kdp_pkg::MAX_ITEMS_DEF,
  parameter int MAX_CAPACITY = kdp_pkg::MAX_CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [kdp_pkg::WGT_W-1:0]  in_item_weight,
  input  logic [kdp_pkg::ITV_W-1:0]  in_item_value,
  input  logic                       in_last_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_result_kind,
  output logic [kdp_pkg::VAL_W-1:0]  out_result_value,
  output logic                       out_items_dropped,
  output logic                       out_last_result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kdp_pkg::CFG_W-1:0]  cfg_data
);
  import kdp_pkg::*;

  logic [CFG_W-1:0] capacity_r;
  kdp_item_t        in_item;
  kdp_item_t        q_item;
  logic             q_valid;
  logic             q_pop;
  kdp_result_t      out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      capacity_r <= cfg_data;
    end
  end

  assign in_item.weight = in_item_weight;
  assign in_item.value  = in_item_value;
  assign in_item.last   = in_last_item;

  kdp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  kdp_back #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .capacity  (capacity_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind   = out_res.kind;
  assign out_result_value  = out_res.value;
  assign out_items_dropped = out_res.dropped;
  assign out_last_result   = out_res.last;

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_weight_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_WEIGHT) |-> !out_items_dropped)
    else $error("drop flag on a chosen weight");

  a_weight_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_WEIGHT) |-> (out_result_value < (1 << WGT_W)))
    else $error("chosen weight out of range");

endmodule

### sim/tb_knapsack_01_dp_with_traceback_top.sv
module tb_knapsack_01_dp_with_traceback_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kdp_pkg::*;

  localparam int NITEMS  = MAX_ITEMS_DEF;
  localparam int NCAP    = MAX_CAPACITY_DEF;
  localparam int ROW_LEN = NCAP + 1;
  localparam logic [VAL_W-1:0] VAL_SAT = {VAL_W{1'b1}};
  localparam int STALL_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [WGT_W-1:0] in_item_weight = '0;
  logic [ITV_W-1:0] in_item_value = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_result_kind;
  logic [VAL_W-1:0] out_result_value;
  logic out_items_dropped;
  logic out_last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  knapsack_01_dp_with_traceback_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_item_weight(in_item_weight), .in_item_value(in_item_value),
    .in_last_item(in_last_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_result_value(out_result_value),
    .out_items_dropped(out_items_dropped), .out_last_result(out_last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [VAL_W-1:0] best_val [ROW_LEN];
  logic             take_bit [NITEMS][ROW_LEN];
  logic [WGT_W-1:0] held_wgt [NITEMS];
  int               held_cnt;
  logic             overflow;
  logic [CFG_W-1:0] cap_reg;

  kdp_result_t answers_q[$];
  int  fail_cnt = 0;
  int  sent_cnt = 0;
  int  got_cnt = 0;
  int  problems = 0;
  int  idle_cnt = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;

  task automatic clear_problem();
    for (int j = 0; j < ROW_LEN; j++) best_val[j] = '0;
    held_cnt = 0;
    overflow = 1'b0;
  endtask

  task automatic solve_step(input logic [WGT_W-1:0] w, input logic [ITV_W-1:0] v,
                            input logic lst);
    int cap, j, n;
    logic [WGT_W-1:0] picked[$];
    logic [VAL_W:0] cand;
    kdp_result_t r;
    if (held_cnt < NITEMS) begin
      held_wgt[held_cnt] = w;
      for (j = NCAP; j >= 0; j--) begin
        take_bit[held_cnt][j] = 1'b0;
        if (w <= j) begin
          cand = best_val[j - w] + v;
          if (cand > VAL_SAT) cand = VAL_SAT;
          if (cand[VAL_W-1:0] > best_val[j]) begin
            best_val[j] = cand[VAL_W-1:0];
            take_bit[held_cnt][j] = 1'b1;
          end
        end
      end
      held_cnt++;
    end else begin
      overflow = 1'b1;
    end
    if (!lst) return;
    cap = (cap_reg > NCAP) ? NCAP : cap_reg;
    j = cap;
    for (int i = held_cnt - 1; i >= 0; i--) begin
      if (take_bit[i][j]) begin
        picked.push_back(held_wgt[i]);
        j = (held_wgt[i] <= j) ? j - held_wgt[i] : 0;
      end
    end
    r.kind = RK_VALUE; r.value = best_val[cap]; r.dropped = overflow;
    r.last = (picked.size() == 0);
    answers_q.push_back(r);
    n = picked.size();
    for (int k = 0; k < n; k++) begin
      r.kind = RK_WEIGHT; r.value = VAL_W'(picked[k]); r.dropped = 1'b0;
      r.last = (k == n - 1);
      answers_q.push_back(r);
    end
    problems++;
    clear_problem();
  endtask

  // in_valid stays high after an accepted word; idling or a register write drops it
  task automatic send_item(input logic [WGT_W-1:0] w, input logic [ITV_W-1:0] v,
                           input logic lst);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item_weight <= w;
    in_item_value <= v;
    in_last_item <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    solve_step(w, v, lst);
    sent_cnt++;
  endtask

  // wait out any in-flight work, then write the capacity
  task automatic write_capacity(input logic [CFG_W-1:0] c);
    in_valid <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk);
    repeat (3 * ROW_LEN + 2 * NITEMS + 16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cap_reg = c;
  endtask

  // receiver side: random stall, check each accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
      if (out_valid && !out_stall) begin
        got_cnt++;
        if (answers_q.size() == 0) begin
          $error("unexpected result word: value %0d", out_result_value);
          fail_cnt++;
        end else begin
          kdp_result_t e;
          e = answers_q.pop_front();
          if (out_result_kind !== e.kind) begin
            $error("result_kind: expected %0d got %0d", e.kind, out_result_kind);
            fail_cnt++;
          end
          if (out_result_value !== e.value) begin
            $error("result_value: expected %0d got %0d", e.value, out_result_value);
            fail_cnt++;
          end
          if (out_items_dropped !== e.dropped) begin
            $error("items_dropped: expected %0d got %0d", e.dropped, out_items_dropped);
            fail_cnt++;
          end
          if (out_last_result !== e.last) begin
            $error("last_result: expected %0d got %0d", e.last, out_last_result);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > STALL_LIMIT) begin
      $display("tb_knapsack_01_dp_with_traceback_top: errors");
      $finish;
    end
  end

  task automatic test_extremes();
    write_capacity(8'd255);
    send_item(8'd0, 16'hFFFF, 1'b0);
    send_item(8'd255, 16'hFFFF, 1'b0);
    send_item(8'd1, 16'd0, 1'b0);
    send_item(8'hAA, 16'hAAAA, 1'b0);
    send_item(8'h55, 16'h5555, 1'b1);
    write_capacity(8'd0);
    send_item(8'd0, 16'd7, 1'b0);
    send_item(8'd1, 16'd100, 1'b1);
    // nothing fits: value result alone
    send_item(8'd5, 16'd9, 1'b1);
  endtask

  task automatic test_saturation();
    write_capacity(8'd64);
    for (int i = 0; i < 32; i++) send_item(8'd0, 16'hFFFF, i == 31);
  endtask

  task automatic test_overflow();
    write_capacity(8'd100);
    for (int i = 0; i < 36; i++)
      send_item(8'($urandom_range(1, 40)), 16'($urandom), i == 35);
  endtask

  task automatic test_cap_midproblem();
    send_item(8'd10, 16'd50, 1'b0);
    send_item(8'd20, 16'd70, 1'b0);
    write_capacity(8'd25);
    send_item(8'd15, 16'd60, 1'b1);
  endtask

  task automatic test_random(input int count);
    int n, k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(3) == 0) write_capacity(8'($urandom));
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        logic [WGT_W-1:0] w;
        w = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60));
        send_item(w, 16'($urandom), i == n - 1);
        k++;
      end
    end
  endtask

  initial begin
    cap_reg = '0;
    clear_problem();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_saturation();
    test_cap_midproblem();
    test_overflow();
    in_idle_pct = 31; out_idle_pct = 63;
    test_random(80);
    in_idle_pct = 63; out_idle_pct = 31;
    test_random(80);
    in_idle_pct = 0; out_idle_pct = 0;
    test_random(80);
    write_capacity(8'd1);
    while (answers_q.size() != 0) @(posedge clk);
    repeat (2 * ROW_LEN + 2 * NITEMS + 16) @(posedge clk);
    $display("covered %0d items in %0d problems, %0d result words checked",
             sent_cnt, problems, got_cnt);
    $display("capacities from 0 to 255, zero weights, dropped items, three idle mixes");
    if (fail_cnt == 0 && answers_q.size() == 0)
      $display("tb_knapsack_01_dp_with_traceback_top: clean");
    else
      $display("tb_knapsack_01_dp_with_traceback_top: errors");
    $finish;
  end
endmodule
